@@ hdl/kvte_pkg.sv @@
// ----------------------------------------------------------------------------
// Key-value table engine package
// Operation, status and sequencer types shared by the table engine files.
// ----------------------------------------------------------------------------
package kvte_pkg;

    localparam int MODE_W   = 2;
    localparam int FLAGS_W  = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int MAX_W    = 5;

    localparam logic [MAX_W-1:0] MAX_RESET = 5'd16;

    // Bit positions in the update flags.
    localparam int FLAG_NO_EXIST = 0;
    localparam int FLAG_EXIST    = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP,
        MODE_UPDATE,
        MODE_DELETE,
        MODE_GET_CREATE
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_EXISTS,
        ST_FULL
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

@@ hdl/kvte_req_if.sv @@
// ----------------------------------------------------------------------------
// Key-value table request channel
// Valid/ready channel that carries one table operation per transaction.
// ----------------------------------------------------------------------------
interface kvte_req_if #(
    parameter int KEY_WIDTH   = 64,
    parameter int VALUE_WIDTH = 64
);
    logic                         valid;
    logic                         ready;
    logic [kvte_pkg::MODE_W-1:0]  mode;
    logic [KEY_WIDTH-1:0]         key;
    logic [VALUE_WIDTH-1:0]       value;
    logic                         value_given;
    logic [kvte_pkg::FLAGS_W-1:0] update_flags;

    modport source (
        output valid, mode, key, value, value_given, update_flags,
        input  ready
    );

    modport sink (
        input  valid, mode, key, value, value_given, update_flags,
        output ready
    );
endinterface

@@ hdl/kvte_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Key-value table response channel
// Valid/ready channel that carries one operation result per transaction.
// ----------------------------------------------------------------------------
interface kvte_rsp_if #(
    parameter int VALUE_WIDTH = 64
);
    logic                          valid;
    logic                          ready;
    logic [kvte_pkg::STATUS_W-1:0] status;
    logic [VALUE_WIDTH-1:0]        value_out;
    logic [kvte_pkg::SLOT_W-1:0]   slot;

    modport source (
        output valid, status, value_out, slot,
        input  ready
    );

    modport sink (
        input  valid, status, value_out, slot,
        output ready
    );
endinterface

@@ hdl/kvte_store.sv @@
// ----------------------------------------------------------------------------
// Key-value table entry store
// Key and value memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kvte_store #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 64,
    parameter int VALUE_WIDTH = 64,
    parameter int AW          = 4
) (
    input  logic                   i_clk,
    input  kvte_pkg::t_mem_ctl     i_ctl,
    input  logic [AW-1:0]          i_rd_addr,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [KEY_WIDTH-1:0]   i_wr_key,
    input  logic [VALUE_WIDTH-1:0] i_wr_val,
    output logic [KEY_WIDTH-1:0]   o_rd_key,
    output logic [VALUE_WIDTH-1:0] o_rd_val
);
    import kvte_pkg::*;

    logic [KEY_WIDTH-1:0]   r_key_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_val_mem [DEPTH];
    logic [KEY_WIDTH-1:0]   r_rd_key;
    logic [VALUE_WIDTH-1:0] r_rd_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_key_mem[i_wr_addr] <= i_wr_key;
            r_val_mem[i_wr_addr] <= i_wr_val;
        end
    end

    // Read data holds between reads; the sequencer relies on that while stalled.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_key <= r_key_mem[i_rd_addr];
            r_rd_val <= r_val_mem[i_rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;
    assign o_rd_val = r_rd_val;

endmodule

@@ hdl/key_value_table_engine_unit.sv @@
// A request scans the entries from slot 0 until its key hits or the last entry is read;
// an empty table skips the scan. A delete that moves the last entry adds a move step.
// A new request is taken only when the sequencer is back in idle, which it enters as the
// result is registered, so the engine works on one operation at a time.
// A result still waiting on the response channel holds the sequencer before its write-back.
// Reset (synchronous, active low) empties the table and sets the capacity limit to 16.
// ----------------------------------------------------------------------------
// Key-value table engine
// Dense key-value table with lookup, update, delete and get-or-create.
// ----------------------------------------------------------------------------
module key_value_table_engine_unit #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [kvte_pkg::MAX_W-1:0]   i_cfg_data,
    kvte_req_if.sink                     i_req,
    kvte_rsp_if.source                   o_rsp
);
    import kvte_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > MAX_W) ? CW : MAX_W;

    t_state                 r_state, n_state;
    t_mode                  r_mode, n_mode;
    logic [KEY_WIDTH-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_val_in, n_val_in;
    logic                   r_given, n_given;
    logic [FLAGS_W-1:0]     r_flags, n_flags;
    logic [CW-1:0]          r_count, n_count;
    logic [MAX_W-1:0]       r_max;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [AW-1:0]          r_pidx, n_pidx;
    logic                   r_hit, n_hit;
    logic [AW-1:0]          r_slot, n_slot;
    logic [VALUE_WIDTH-1:0] r_hval, n_hval;
    logic                   r_ovalid, n_ovalid;
    t_status                r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_vout, n_vout;
    logic [SLOT_W-1:0]      r_oslot, n_oslot;

    t_mem_ctl               mem_ctl;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key, rd_key;
    logic [VALUE_WIDTH-1:0] wr_val, rd_val;

    logic                   req_fire, out_free;
    logic [CW-1:0]          last;
    logic                   scan_hit, scan_last, scan_issue;
    logic                   room, go_move;

    t_status                dec_status;
    logic [VALUE_WIDTH-1:0] dec_val, dec_wr_val;
    logic [AW-1:0]          dec_slot, dec_wr_addr;
    logic                   dec_wr, dec_inc, dec_dec;

    logic                   emit;
    t_status                e_status;
    logic [VALUE_WIDTH-1:0] e_val;
    logic [AW-1:0]          e_slot;
    logic [AW+SLOT_W-1:0]   slot_ext;

    kvte_store #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_val  (wr_val),
        .o_rd_key  (rd_key),
        .o_rd_val  (rd_val)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_ovalid || o_rsp.ready;

    assign last       = r_count - 1'b1;
    assign scan_hit   = r_pend && (rd_key == r_key);
    assign scan_last  = r_pend && (CW'(r_pidx) == last);
    assign scan_issue = (r_idx < r_count);

    // The capacity is the configured limit saturated at the table depth.
    assign room    = (MW'(r_count) < MW'(r_max)) && (r_count < CW'(DEPTH));
    assign go_move = (r_mode == MODE_DELETE) && r_hit && (CW'(r_slot) != last);

    always_comb begin
        dec_status  = ST_OK;
        dec_val     = '0;
        dec_slot    = r_slot;
        dec_wr      = 1'b0;
        dec_wr_addr = r_slot;
        dec_wr_val  = r_val_in;
        dec_inc     = 1'b0;
        dec_dec     = 1'b0;
        unique case (r_mode)
            MODE_LOOKUP: begin
                if (r_hit) begin
                    dec_val = r_hval;
                end else begin
                    dec_status = ST_NOT_FOUND;
                end
            end
            MODE_UPDATE: begin
                if (r_hit) begin
                    if (r_flags[FLAG_NO_EXIST]) begin
                        dec_status = ST_EXISTS;
                    end else begin
                        dec_wr  = 1'b1;
                        dec_val = r_val_in;
                    end
                end else if (r_flags[FLAG_EXIST]) begin
                    dec_status = ST_NOT_FOUND;
                end else if (room) begin
                    dec_wr      = 1'b1;
                    dec_wr_addr = r_count[AW-1:0];
                    dec_slot    = r_count[AW-1:0];
                    dec_inc     = 1'b1;
                    dec_val     = r_val_in;
                end else begin
                    dec_status = ST_FULL;
                end
            end
            MODE_DELETE: begin
                if (r_hit) begin
                    dec_dec = 1'b1;
                end else begin
                    dec_status = ST_NOT_FOUND;
                end
            end
            MODE_GET_CREATE: begin
                if (r_hit) begin
                    dec_val = r_hval;
                end else if (room) begin
                    dec_wr      = 1'b1;
                    dec_wr_addr = r_count[AW-1:0];
                    dec_slot    = r_count[AW-1:0];
                    dec_inc     = 1'b1;
                    dec_wr_val  = r_given ? r_val_in : '0;
                    dec_val     = r_given ? r_val_in : '0;
                end else begin
                    dec_status = ST_FULL;
                end
            end
            default: begin
                dec_status = ST_NOT_FOUND;
            end
        endcase
        if (dec_status != ST_OK) begin
            dec_val  = '0;
            dec_slot = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_state = (r_count == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (go_move) begin
                    n_state = S_MOVE;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MOVE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_key    = r_key;
        n_val_in = r_val_in;
        n_given  = r_given;
        n_flags  = r_flags;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pidx   = r_pidx;
        n_hit    = r_hit;
        n_slot   = r_slot;
        n_hval   = r_hval;
        mem_ctl  = '0;
        rd_addr  = r_idx[AW-1:0];
        wr_addr  = dec_wr_addr;
        wr_key   = r_key;
        wr_val   = dec_wr_val;
        emit     = 1'b0;
        e_status = dec_status;
        e_val    = dec_val;
        e_slot   = dec_slot;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_mode   = t_mode'(i_req.mode);
                    n_key    = i_req.key;
                    n_val_in = i_req.value;
                    n_given  = i_req.value_given;
                    n_flags  = i_req.update_flags;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                end
            end
            S_SCAN: begin
                // Reads are issued ahead of the compare; the store registers each returned key.
                if (scan_hit) begin
                    n_hit  = 1'b1;
                    n_slot = r_pidx;
                    n_hval = rd_val;
                    n_pend = 1'b0;
                end else if (scan_last) begin
                    n_hit  = 1'b0;
                    n_pend = 1'b0;
                end else begin
                    mem_ctl.rd_en = scan_issue;
                    n_pend        = scan_issue;
                    n_pidx        = r_idx[AW-1:0];
                    if (scan_issue) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DECIDE: begin
                if (go_move) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = last[AW-1:0];
                end else if (out_free) begin
                    emit           = 1'b1;
                    mem_ctl.wr_en  = dec_wr;
                    if (dec_inc) begin
                        n_count = r_count + 1'b1;
                    end else if (dec_dec) begin
                        n_count = last;
                    end
                end
            end
            S_MOVE: begin
                // The last entry fills the freed slot to keep the list dense.
                if (out_free) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = r_slot;
                    wr_key        = rd_key;
                    wr_val        = rd_val;
                    n_count       = last;
                    emit          = 1'b1;
                    e_status      = ST_OK;
                    e_val         = '0;
                    e_slot        = r_slot;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    assign slot_ext = {{SLOT_W{1'b0}}, e_slot};

    always_comb begin
        n_ovalid = r_ovalid;
        n_status = r_status;
        n_vout   = r_vout;
        n_oslot  = r_oslot;
        if (emit) begin
            n_ovalid = 1'b1;
            n_status = e_status;
            n_vout   = e_val;
            n_oslot  = slot_ext[SLOT_W-1:0];
        end else if (o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_max    <= MAX_RESET;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_val_in <= n_val_in;
        r_given  <= n_given;
        r_flags  <= n_flags;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_hit    <= n_hit;
        r_slot   <= n_slot;
        r_hval   <= n_hval;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_oslot  <= n_oslot;
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.status    = r_status;
    assign o_rsp.value_out = r_vout;
    assign o_rsp.slot      = r_oslot;

endmodule

@@ hdl/kvte_checker.sv @@
// ----------------------------------------------------------------------------
// Key-value table engine checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module kvte_checker #(
    parameter int VALUE_WIDTH = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [kvte_pkg::STATUS_W-1:0] i_status,
    input logic [VALUE_WIDTH-1:0]        i_value_out,
    input logic [kvte_pkg::SLOT_W-1:0]   i_slot
);
    import kvte_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_value_out) && $stable(i_slot))
        else $error("response changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> (i_value_out == '0) && (i_slot == '0))
        else $error("failed operation reported a value or slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while an operation is in progress");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after a request");

endmodule

bind key_value_table_engine_unit kvte_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_kvte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_value_out (o_rsp.value_out),
    .i_slot      (o_rsp.slot)
);
